/* src/ittt_pkg.sv */
// shared types and constants for the id tagged timer table
`timescale 1ns / 1ps

package ittt_pkg;

   localparam int SLOT_COUNT = 16;
   localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
   localparam int ID_W       = 16;
   localparam int COUNT_W    = 32;
   localparam int OP_W       = 3;

   localparam logic [COUNT_W-1:0] TICK_STEP = COUNT_W'(2);

   typedef enum logic [OP_W-1:0] {
      OP_TICK      = 3'd0,
      OP_REGISTER  = 3'd1,
      OP_CANCEL    = 3'd2,
      OP_REMAINING = 3'd3,
      OP_EXPIRED   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [COUNT_W-1:0] count;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } store_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } store_rd_type;

endpackage

/* src/id_tagged_timer_table_top.sv */
// top level of the id tagged timer table
// sequence: an item goes from the idle state through a scan of all 16 slots of the
//   registered slot memory, an update state and a finish state that loads the result
// flow: a new item is taken only in the idle state, once the last one has left the
//   finish state; a stalled result holds the item after it in the finish state
// reset: synchronous, clears the sequencer, the result valid flag and all slot valid
//   bits at once, so every slot reads as free with a zero count right after reset
`timescale 1ns / 1ps

module id_tagged_timer_table_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ittt_pkg::OP_W-1:0]      req_opcode,
   input  logic [ittt_pkg::ID_W-1:0]      req_timer_id,
   input  logic [ittt_pkg::COUNT_W-1:0]   req_load_count,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_success,
   output logic [ittt_pkg::COUNT_W-1:0]   rsp_remaining
);

   localparam logic [ittt_pkg::IDX_W-1:0] LAST_IDX = ittt_pkg::IDX_W'(ittt_pkg::SLOT_COUNT - 1);
   localparam logic [ittt_pkg::CNT_W-1:0] CNT_END  = ittt_pkg::CNT_W'(ittt_pkg::SLOT_COUNT);

   ittt_pkg::state_type            state_ff, state_in;
   logic [ittt_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [ittt_pkg::OP_W-1:0]      op_ff, op_in;
   logic [ittt_pkg::ID_W-1:0]      id_ff, id_in;
   logic [ittt_pkg::COUNT_W-1:0]   load_ff, load_in;
   logic                           hit_ff, hit_in;
   logic [ittt_pkg::IDX_W-1:0]     hit_idx_ff, hit_idx_in;
   logic [ittt_pkg::COUNT_W-1:0]   hit_cnt_ff, hit_cnt_in;
   logic                           free_ff, free_in;
   logic [ittt_pkg::IDX_W-1:0]     free_idx_ff, free_idx_in;
   logic                           ok_ff, ok_in;
   logic [ittt_pkg::COUNT_W-1:0]   rem_ff, rem_in;
   logic                           rd_valid_ff;
   logic [ittt_pkg::IDX_W-1:0]     rd_idx_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_success_ff, rsp_success_in;
   logic [ittt_pkg::COUNT_W-1:0]   rsp_remaining_ff, rsp_remaining_in;

   ittt_pkg::store_wr_type         wr;
   ittt_pkg::store_rd_type         rd;
   ittt_pkg::entry_type            entry;
   logic                           req_known;

   ittt_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd      (rd),
      .rd_data (entry)
   );

   assign req_known = (req_opcode inside {ittt_pkg::OP_REGISTER, ittt_pkg::OP_CANCEL,
                                          ittt_pkg::OP_REMAINING, ittt_pkg::OP_EXPIRED});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ittt_pkg::ST_IDLE;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd.en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff           <= cnt_in;
      op_ff            <= op_in;
      id_ff            <= id_in;
      load_ff          <= load_in;
      hit_ff           <= hit_in;
      hit_idx_ff       <= hit_idx_in;
      hit_cnt_ff       <= hit_cnt_in;
      free_ff          <= free_in;
      free_idx_ff      <= free_idx_in;
      ok_ff            <= ok_in;
      rem_ff           <= rem_in;
      rd_idx_ff        <= rd.addr;
      rsp_success_ff   <= rsp_success_in;
      rsp_remaining_ff <= rsp_remaining_in;
   end

   always_comb begin
      state_in         = state_ff;
      cnt_in           = cnt_ff;
      op_in            = op_ff;
      id_in            = id_ff;
      load_in          = load_ff;
      hit_in           = hit_ff;
      hit_idx_in       = hit_idx_ff;
      hit_cnt_in       = hit_cnt_ff;
      free_in          = free_ff;
      free_idx_in      = free_idx_ff;
      ok_in            = ok_ff;
      rem_in           = rem_ff;
      rsp_valid_in     = rsp_valid_ff & rsp_stall;
      rsp_success_in   = rsp_success_ff;
      rsp_remaining_in = rsp_remaining_ff;
      rd.en            = 1'b0;
      rd.addr          = cnt_ff[ittt_pkg::IDX_W-1:0];
      wr               = '0;

      case (state_ff)
         ittt_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in   = req_opcode;
               id_in   = req_timer_id;
               load_in = req_load_count;
               cnt_in  = '0;
               hit_in  = 1'b0;
               free_in = 1'b0;
               ok_in   = 1'b0;
               rem_in  = '0;
               if (req_opcode == ittt_pkg::OP_TICK ||
                   (req_known && req_timer_id != '0)) begin
                  state_in = ittt_pkg::ST_SCAN;
               end else begin
                  state_in = ittt_pkg::ST_FINISH;
               end
            end
         end
         ittt_pkg::ST_SCAN: begin
            if (cnt_ff != CNT_END) begin
               rd.en  = 1'b1;
               cnt_in = cnt_ff + ittt_pkg::CNT_W'(1);
            end
            if (rd_valid_ff) begin
               if (op_ff == ittt_pkg::OP_TICK) begin
                  // saturating decrement, written back behind the read pointer
                  wr.en      = 1'b1;
                  wr.addr    = rd_idx_ff;
                  wr.data.id = entry.id;
                  wr.data.count = (entry.count >= ittt_pkg::TICK_STEP) ?
                                  entry.count - ittt_pkg::TICK_STEP : '0;
               end else begin
                  if (!hit_ff && entry.id == id_ff) begin
                     hit_in     = 1'b1;
                     hit_idx_in = rd_idx_ff;
                     hit_cnt_in = entry.count;
                  end
                  if (!free_ff && entry.id == '0) begin
                     free_in     = 1'b1;
                     free_idx_in = rd_idx_ff;
                  end
               end
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = ittt_pkg::ST_UPDATE;
               end
            end
         end
         ittt_pkg::ST_UPDATE: begin
            state_in = ittt_pkg::ST_FINISH;
            case (op_ff)
               ittt_pkg::OP_TICK: begin
                  ok_in = 1'b1;
               end
               ittt_pkg::OP_REGISTER: begin
                  if (hit_ff || free_ff) begin
                     wr.en         = 1'b1;
                     wr.addr       = hit_ff ? hit_idx_ff : free_idx_ff;
                     wr.data.id    = id_ff;
                     wr.data.count = load_ff;
                     ok_in         = 1'b1;
                  end
               end
               ittt_pkg::OP_CANCEL: begin
                  if (hit_ff) begin
                     wr.en   = 1'b1;
                     wr.addr = hit_idx_ff;
                     ok_in   = 1'b1;
                  end
               end
               ittt_pkg::OP_REMAINING: begin
                  if (hit_ff) begin
                     rem_in = hit_cnt_ff;
                     ok_in  = 1'b1;
                  end
               end
               ittt_pkg::OP_EXPIRED: begin
                  if (hit_ff && hit_cnt_ff == '0) begin
                     wr.en   = 1'b1;
                     wr.addr = hit_idx_ff;
                     ok_in   = 1'b1;
                  end
               end
               default: begin
                  ok_in = 1'b0;
               end
            endcase
         end
         ittt_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in     = 1'b1;
               rsp_success_in   = ok_ff;
               rsp_remaining_in = rem_ff;
               state_in         = ittt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ittt_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_stall     = (state_ff != ittt_pkg::ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_success   = rsp_success_ff;
   assign rsp_remaining = rsp_remaining_ff;

endmodule

/* src/ittt_store.sv */
// slot memory with per-entry valid bits so unwritten slots read as free
`timescale 1ns / 1ps

module ittt_store (
   input  logic                    clock,
   input  logic                    reset,
   input  ittt_pkg::store_wr_type  wr,
   input  ittt_pkg::store_rd_type  rd,
   output ittt_pkg::entry_type     rd_data
);

   ittt_pkg::entry_type                 mem [ittt_pkg::SLOT_COUNT];
   logic [ittt_pkg::SLOT_COUNT-1:0]     vld_ff;
   ittt_pkg::entry_type                 rd_raw_ff;
   logic                                rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_raw_ff <= mem[rd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            vld_ff[wr.addr] <= 1'b1;
         end
         if (rd.en) begin
            rd_vld_ff <= vld_ff[rd.addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_raw_ff : '0;

endmodule

/* src/ittt_checker.sv */
// port-level checks for the id tagged timer table
`timescale 1ns / 1ps

module ittt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic                           rsp_success,
   input logic [ittt_pkg::COUNT_W-1:0]   rsp_remaining
);

   // held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_success) && $stable(rsp_remaining))
      else $error("result changed while stalled");

   // a count is only reported with success
   a_rem_success: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_success |-> rsp_remaining == '0)
      else $error("nonzero remaining on failed result");

   // one item in flight: the input side closes right after a transfer
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while one is in work");

   // no result out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind id_tagged_timer_table_top ittt_checker u_ittt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_success   (rsp_success),
   .rsp_remaining (rsp_remaining)
);
